// File: sv/ctrgb_pkg.sv
// ctrgb_pkg: shared types, Q20 constants and elaboration-time helpers
// for the colour temperature to RGB pipeline. No dependencies.
package ctrgb_pkg;

  localparam int QF        = 20;
  localparam int LOG_STEPS = QF;
  localparam int EXP_STEPS = QF;

  // Q20 constants, rounded to nearest
  localparam logic [31:0] R_MUL  = 32'(((64'd329698727446 << 20) + 64'd1000000000 / 2)
                                       / 64'd1000000000);
  localparam logic [31:0] R_EXP  = 32'(((64'd1332047592 << 20) + 64'd10000000000 / 2)
                                       / 64'd10000000000);
  localparam logic [31:0] G_LMUL = 32'(((64'd994708025861 << 20) + 64'd10000000000 / 2)
                                       / 64'd10000000000);
  localparam logic [31:0] G_LOFF = 32'(((64'd1611195681661 << 20) + 64'd10000000000 / 2)
                                       / 64'd10000000000);
  localparam logic [31:0] G_PMUL = 32'(((64'd2881221695283 << 20) + 64'd10000000000 / 2)
                                       / 64'd10000000000);
  localparam logic [31:0] G_EXP  = 32'(((64'd755148492 << 20) + 64'd10000000000 / 2)
                                       / 64'd10000000000);
  localparam logic [31:0] B_MUL  = 32'(((64'd1385177312231 << 20) + 64'd10000000000 / 2)
                                       / 64'd10000000000);
  localparam logic [31:0] B_OFF  = 32'(((64'd3050447927307 << 20) + 64'd10000000000 / 2)
                                       / 64'd10000000000);
  localparam logic [31:0] LN2_Q  = 32'(((64'd6931471805599 << 20) + 64'd10000000000000 / 2)
                                       / 64'd10000000000000);
  localparam logic [31:0] HALF_Q = 32'd1 << (QF - 1);
  localparam logic [31:0] FULL_Q = 32'd255 << QF;
  localparam logic [30:0] ONE_Q30 = 31'd1 << 30;

  localparam logic [15:0] K_KNEE   = 16'd6600;
  localparam logic [15:0] K_BLUE0  = 16'd1900;
  localparam logic [15:0] K_GREEN0 = 16'd100;
  localparam logic [15:0] K_POFF   = 16'd6000;
  localparam logic [15:0] K_BOFF   = 16'd1000;

  typedef struct packed {
    logic sel_log;  // t <= 66: red full, green on the log curve
    logic g_zero;   // t <= 1
    logic b_full;   // t >= 66
    logic b_zero;   // t <= 19
  } flags_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] b;
    x   = v;
    res = 64'd0;
    for (int s = 31; s >= 0; s--) begin
      b = 64'd1 << (2 * s);
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // 2^(2^-n) in Q30
  function automatic logic [63:0] root_q30(input int n);
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int i = 1; i <= n; i++) begin
      r = isqrt64(r << 30);
    end
    return r;
  endfunction

  // log2 of a 16-bit integer, Q20 (0 for 0)
  function automatic logic [63:0] log2_int_c(input logic [15:0] num);
    logic [63:0] m;
    logic [63:0] r;
    int          p;
    p = 0;
    for (int j = 0; j < 16; j++) begin
      if (num[j]) p = j;
    end
    m = 64'(num) << (30 - p);
    r = 64'(p) << QF;
    for (int i = 1; i <= QF; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r = r | (64'd1 << (QF - i));
      end
    end
    if (num == 16'd0) r = 64'd0;
    return r;
  endfunction

  localparam logic [23:0] L100 = 24'(log2_int_c(16'd100));

endpackage

// File: sv/color_temperature_to_rgb_top.sv
// color_temperature_to_rgb_top: pipelined colour temperature to RGB converter.
// Depends on ctrgb_pkg (constants, flags_t, root and log2 helpers).
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+--------------------------
//  input   | start, busy, in_kelvin[15:0]            | word taken: start & !busy
//  result  | out_valid, out_red/green/blue[7:0]      | one-cycle strobe, no stall
//
// One word enters every cycle; busy is never raised.
// Stages, in order: input reg, prep, 20 log2 squaring stages,
// log offset, exponent/ln multiply, scale/exp prep, 20 exp2 root stages,
// shift, final multiply, clamp and round. No stage chains two multipliers.
// Synchronous active-low reset clears the valid chain only; data regs float.
// The receiver cannot stall, so the pipeline never holds.
module color_temperature_to_rgb_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_kelvin,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  localparam int QF  = ctrgb_pkg::QF;
  localparam int NL  = ctrgb_pkg::LOG_STEPS;
  localparam int NE  = ctrgb_pkg::EXP_STEPS;
  // stage indices (0 = input register)
  localparam int S_T = NL + 2;      // log2(t) offset
  localparam int S_X = S_T + 3 + NE;
  localparam int LAT = S_X + 3;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------- valid and flag chains ----------------
  logic                vld_r [LAT];
  ctrgb_pkg::flags_t   fl_r  [LAT];
  ctrgb_pkg::flags_t   fl_in;

  always_comb begin
    fl_in.sel_log = (in_kelvin <= ctrgb_pkg::K_KNEE);
    fl_in.g_zero  = (in_kelvin <= ctrgb_pkg::K_GREEN0);
    fl_in.b_full  = (in_kelvin >= ctrgb_pkg::K_KNEE);
    fl_in.b_zero  = (in_kelvin <= ctrgb_pkg::K_BLUE0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= accept;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    fl_r[0] <= fl_in;
    for (int i = 1; i < LAT; i++) fl_r[i] <= fl_r[i-1];
  end

  // ---------------- stage 0: input word ----------------
  logic [15:0] k0_r;
  always_ff @(posedge clk) begin
    k0_r <= in_kelvin;
  end

  // ---------------- stage 1: normalise log arguments ----------------
  // unit 0: green log (t <= 66) or both power curves (t - 60)
  // unit 1: blue log of t - 10
  logic [30:0] lg_m_r [2][NL+1];
  logic [3:0]  lg_p_r [2][NL+1];
  logic        lg_z_r [2][NL+1];
  logic [QF-1:0] lg_f_r [2][NL+1];

  logic [15:0] num [2];
  logic [3:0]  msb [2];

  always_comb begin
    num[0] = fl_r[0].sel_log ? k0_r : k0_r - ctrgb_pkg::K_POFF;
    num[1] = k0_r - ctrgb_pkg::K_BOFF;
    for (int u = 0; u < 2; u++) begin
      msb[u] = 4'd0;
      for (int j = 0; j < 16; j++) begin
        if (num[u][j]) msb[u] = 4'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    lg_m_r[0][0] <= {15'd0, num[0]} << (5'd30 - {1'b0, msb[0]});
    lg_p_r[0][0] <= msb[0];
    lg_z_r[0][0] <= (num[0] == 16'd0);
    lg_f_r[0][0] <= '0;
    lg_m_r[1][0] <= {15'd0, num[1]} << (5'd30 - {1'b0, msb[1]});
    lg_p_r[1][0] <= msb[1];
    lg_z_r[1][0] <= (num[1] == 16'd0);
    lg_f_r[1][0] <= '0;
  end

  // ---------------- log2 squaring stages ----------------
  for (genvar gu = 0; gu < 2; gu++) begin : g_logu
    for (genvar gi = 1; gi <= NL; gi++) begin : g_logs
      logic [61:0]   sq;
      logic [31:0]   sq_hi;
      logic [30:0]   m_nxt;
      logic [QF-1:0] f_nxt;
      always_comb begin
        sq    = 62'(lg_m_r[gu][gi-1]) * 62'(lg_m_r[gu][gi-1]);
        sq_hi = sq[61:30];
        f_nxt = lg_f_r[gu][gi-1];
        f_nxt[QF-gi] = sq_hi[31];
        m_nxt = sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
      end
      always_ff @(posedge clk) begin
        lg_m_r[gu][gi] <= m_nxt;
        lg_f_r[gu][gi] <= f_nxt;
        lg_p_r[gu][gi] <= lg_p_r[gu][gi-1];
        lg_z_r[gu][gi] <= lg_z_r[gu][gi-1];
      end
    end
  end

  // ---------------- stage T: log2(num/100) ----------------
  logic [23:0] lraw [2];
  logic [23:0] l_r  [2];
  always_comb begin
    for (int u = 0; u < 2; u++) begin
      lraw[u] = lg_z_r[u][NL] ? 24'd0 : {lg_p_r[u][NL], lg_f_r[u][NL]};
    end
  end
  always_ff @(posedge clk) begin
    for (int u = 0; u < 2; u++) begin
      l_r[u] <= (lraw[u] > ctrgb_pkg::L100) ? lraw[u] - ctrgb_pkg::L100 : 24'd0;
    end
  end

  // ---------------- stage U: ln and power exponents ----------------
  logic [63:0] p_lng, p_lnb, p_ar, p_ag;
  logic [23:0] lng_r, lnb_r, ar_r, ag_r;
  always_comb begin
    p_lng = 64'(l_r[0]) * 64'(ctrgb_pkg::LN2_Q) + 64'(ctrgb_pkg::HALF_Q);
    p_lnb = 64'(l_r[1]) * 64'(ctrgb_pkg::LN2_Q) + 64'(ctrgb_pkg::HALF_Q);
    p_ar  = 64'(l_r[0]) * 64'(ctrgb_pkg::R_EXP) + 64'(ctrgb_pkg::HALF_Q);
    p_ag  = 64'(l_r[0]) * 64'(ctrgb_pkg::G_EXP) + 64'(ctrgb_pkg::HALF_Q);
  end
  always_ff @(posedge clk) begin
    lng_r <= p_lng[43:20];
    lnb_r <= p_lnb[43:20];
    ar_r  <= p_ar[43:20];
    ag_r  <= p_ag[43:20];
  end

  // ---------------- stage W: log scaling, exp2 set-up ----------------
  logic [63:0] p_vg, p_vb;
  logic [31:0] dl_vg_r [NE+1];
  logic [31:0] dl_vb_r [NE+1];
  logic [30:0] ex_v_r  [2][NE+1];
  logic [4:0]  ex_ip_r [2][NE+1];
  logic [QF-1:0] ex_fr_r [2][NE+1];
  logic [23:0] aexp [2];
  logic [4:0]  ip0  [2];
  logic [QF-1:0] fr0 [2];

  always_comb begin
    p_vg = 64'(ctrgb_pkg::G_LMUL) * 64'(lng_r) + 64'(ctrgb_pkg::HALF_Q);
    p_vb = 64'(ctrgb_pkg::B_MUL) * 64'(lnb_r) + 64'(ctrgb_pkg::HALF_Q);
    aexp[0] = ar_r;
    aexp[1] = ag_r;
    for (int u = 0; u < 2; u++) begin
      // 2^-a = 2^-(ip+1) * 2^(1-frac) when a has a fraction
      ip0[u] = {1'b0, aexp[u][23:20]};
      fr0[u] = aexp[u][QF-1:0];
      if (fr0[u] != '0) begin
        ip0[u] = ip0[u] + 5'd1;
        fr0[u] = ~fr0[u] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dl_vg_r[0] <= p_vg[51:20];
    dl_vb_r[0] <= p_vb[51:20];
    ex_v_r[0][0]  <= ctrgb_pkg::ONE_Q30;
    ex_ip_r[0][0] <= ip0[0];
    ex_fr_r[0][0] <= fr0[0];
    ex_v_r[1][0]  <= ctrgb_pkg::ONE_Q30;
    ex_ip_r[1][0] <= ip0[1];
    ex_fr_r[1][0] <= fr0[1];
  end

  // ---------------- exp2 root product stages ----------------
  for (genvar gj = 1; gj <= NE; gj++) begin : g_exps
    localparam logic [30:0] ROOT = 31'(ctrgb_pkg::root_q30(gj));
    always_ff @(posedge clk) begin
      dl_vg_r[gj] <= dl_vg_r[gj-1];
      dl_vb_r[gj] <= dl_vb_r[gj-1];
    end
    for (genvar gu = 0; gu < 2; gu++) begin : g_expu
      logic [61:0] prod;
      assign prod = 62'(ex_v_r[gu][gj-1]) * 62'(ROOT);
      always_ff @(posedge clk) begin
        ex_v_r[gu][gj]  <= ex_fr_r[gu][gj-1][QF-gj] ? prod[60:30] : ex_v_r[gu][gj-1];
        ex_ip_r[gu][gj] <= ex_ip_r[gu][gj-1];
        ex_fr_r[gu][gj] <= ex_fr_r[gu][gj-1];
      end
    end
  end

  // ---------------- stage X: integer part shift ----------------
  logic [30:0] sh_r [2];
  logic [31:0] xg_r, xb_r;
  always_ff @(posedge clk) begin
    for (int u = 0; u < 2; u++) begin
      sh_r[u] <= (ex_ip_r[u][NE] >= 5'd31) ? 31'd0 : ex_v_r[u][NE] >> ex_ip_r[u][NE];
    end
    xg_r <= dl_vg_r[NE];
    xb_r <= dl_vb_r[NE];
  end

  // ---------------- stage Y: power scaling, log offsets ----------------
  logic [63:0] p_pr, p_pg;
  logic [31:0] pr_r, pg_r, gl_r, bl_r;
  always_comb begin
    p_pr = 64'(ctrgb_pkg::R_MUL) * 64'(sh_r[0]);
    p_pg = 64'(ctrgb_pkg::G_PMUL) * 64'(sh_r[1]);
  end
  always_ff @(posedge clk) begin
    pr_r <= p_pr[61:30];
    pg_r <= p_pg[61:30];
    gl_r <= (xg_r > ctrgb_pkg::G_LOFF) ? xg_r - ctrgb_pkg::G_LOFF : 32'd0;
    bl_r <= (xb_r > ctrgb_pkg::B_OFF) ? xb_r - ctrgb_pkg::B_OFF : 32'd0;
  end

  // ---------------- stage Z: select, clamp, round ----------------
  function automatic logic [7:0] to_level(input logic [31:0] v);
    logic [31:0] c;
    c = (v > ctrgb_pkg::FULL_Q) ? ctrgb_pkg::FULL_Q : v;
    c = c + ctrgb_pkg::HALF_Q;
    return c[QF+7:QF];
  endfunction

  ctrgb_pkg::flags_t fz;
  logic [31:0] rsel, gsel, bsel;
  always_comb begin
    fz   = fl_r[LAT-2];
    rsel = fz.sel_log ? ctrgb_pkg::FULL_Q : pr_r;
    gsel = fz.sel_log ? (fz.g_zero ? 32'd0 : gl_r) : pg_r;
    if (fz.b_full)      bsel = ctrgb_pkg::FULL_Q;
    else if (fz.b_zero) bsel = 32'd0;
    else                bsel = bl_r;
  end

  always_ff @(posedge clk) begin
    out_red   <= to_level(rsel);
    out_green <= to_level(gsel);
    out_blue  <= to_level(bsel);
  end
  assign out_valid = vld_r[LAT-1];

  // ---------------- checks ----------------
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result word without matching input word");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept, LAT) && $past(rst_n, LAT) |-> out_valid)
    else $error("input word lost");

  a_red_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($past(in_kelvin, LAT) <= ctrgb_pkg::K_KNEE) |-> out_red == 8'd255)
    else $error("red not full at low temperature");

  a_blue_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($past(in_kelvin, LAT) >= ctrgb_pkg::K_KNEE) |-> out_blue == 8'd255)
    else $error("blue not full at high temperature");

  a_blue_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($past(in_kelvin, LAT) <= ctrgb_pkg::K_BLUE0) |-> out_blue == 8'd0)
    else $error("blue not zero at low temperature");

endmodule

// File: bench/color_temperature_to_rgb_top_test.sv
// color_temperature_to_rgb_top_test: self-checking bench for the colour
// temperature to RGB pipeline. Depends on ctrgb_pkg and color_temperature_to_rgb_top.
// Driver feeds words from a queue; monitor checks each strobe against a bit-exact predictor.
module color_temperature_to_rgb_top_test;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam int LAT = 48;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_kelvin;
  logic        out_valid;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;

  logic [15:0] kelvin_queue[$];   // words still to be driven
  rgb_t        rgb_expected[$];   // predicted levels, oldest first
  int          gap_left;
  int          errors = 0;
  int          words_sent;
  int          words_checked = 0;

  color_temperature_to_rgb_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_kelvin(in_kelvin),
    .out_valid(out_valid), .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  // Floor square root by the usual bit-pair method.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem  = v;
    root = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // log2 of a whole number in Q20; squaring of a Q30 mantissa, truncated
  function automatic logic [63:0] log2_whole(input logic [15:0] num);
    logic [63:0] mant;
    logic [63:0] acc;
    int          msb;
    if (num == 16'd0) return 64'd0;
    msb = 0;
    for (int j = 0; j < 16; j++) if (num[j]) msb = j;
    mant = 64'(num) << (30 - msb);
    acc  = 64'(msb) << ctrgb_pkg::QF;
    for (int i = 1; i <= ctrgb_pkg::QF; i++) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        acc  = acc | (64'd1 << (ctrgb_pkg::QF - i));
      end
    end
    return acc;
  endfunction

  // log2(num/100), floored at zero
  function automatic logic [63:0] log2_hundredths(input logic [15:0] num);
    logic [63:0] a;
    logic [63:0] b;
    a = log2_whole(num);
    b = log2_whole(16'd100);
    return (a > b) ? a - b : 64'd0;
  endfunction

  // 2^-a, a in Q20, result Q30
  function automatic logic [63:0] pow2_neg(input logic [63:0] a);
    logic [63:0] ip;
    logic [63:0] fr;
    logic [63:0] prod;
    logic [63:0] root;
    ip   = a >> ctrgb_pkg::QF;
    fr   = a & ((64'd1 << ctrgb_pkg::QF) - 1);
    prod = 64'd1 << 30;
    root = 64'd1 << 31;
    if (fr != 0) begin
      ip = ip + 1;
      fr = (64'd1 << ctrgb_pkg::QF) - fr;
    end
    for (int i = 1; i <= ctrgb_pkg::QF; i++) begin
      root = floor_sqrt(root << 30);
      if (fr[ctrgb_pkg::QF - i]) prod = (prod * root) >> 30;
    end
    if (ip >= 31) return 64'd0;
    return prod >> ip;
  endfunction

  function automatic logic [63:0] power_curve(input logic [15:0] num,
                                              input logic [63:0] mul, input logic [63:0] ex);
    logic [63:0] a;
    a = (ex * log2_hundredths(num) + 64'(ctrgb_pkg::HALF_Q)) >> ctrgb_pkg::QF;
    return (mul * pow2_neg(a)) >> 30;
  endfunction

  function automatic logic [63:0] log_curve(input logic [15:0] num,
                                            input logic [63:0] mul, input logic [63:0] off);
    logic [63:0] ln;
    logic [63:0] v;
    ln = (log2_hundredths(num) * 64'(ctrgb_pkg::LN2_Q) + 64'(ctrgb_pkg::HALF_Q))
         >> ctrgb_pkg::QF;
    v  = (mul * ln + 64'(ctrgb_pkg::HALF_Q)) >> ctrgb_pkg::QF;
    return (v > off) ? v - off : 64'd0;
  endfunction

  function automatic logic [7:0] level_of(input logic [63:0] v);
    logic [63:0] c;
    c = (v > 64'(ctrgb_pkg::FULL_Q)) ? 64'(ctrgb_pkg::FULL_Q) : v;
    return 8'((c + 64'(ctrgb_pkg::HALF_Q)) >> ctrgb_pkg::QF);
  endfunction

  function automatic rgb_t kelvin_to_rgb(input logic [15:0] k);
    logic [63:0] r;
    logic [63:0] g;
    logic [63:0] b;
    rgb_t        res;
    if (k <= 16'd6600) begin
      r = 64'(ctrgb_pkg::FULL_Q);
      g = (k <= 16'd100) ? 64'd0 :
          log_curve(k, 64'(ctrgb_pkg::G_LMUL), 64'(ctrgb_pkg::G_LOFF));
    end else begin
      r = power_curve(k - 16'd6000, 64'(ctrgb_pkg::R_MUL), 64'(ctrgb_pkg::R_EXP));
      g = power_curve(k - 16'd6000, 64'(ctrgb_pkg::G_PMUL), 64'(ctrgb_pkg::G_EXP));
    end
    if (k >= 16'd6600) b = 64'(ctrgb_pkg::FULL_Q);
    else if (k <= 16'd1900) b = 64'd0;
    else b = log_curve(k - 16'd1000, 64'(ctrgb_pkg::B_MUL), 64'(ctrgb_pkg::B_OFF));
    res.red   = level_of(r);
    res.green = level_of(g);
    res.blue  = level_of(b);
    return res;
  endfunction

  // ---------------------------------------------------------------- driver
  // A word is taken at an edge with start high and busy low. Each time a
  // word is driven a fresh random gap is drawn; in bursts it is forced
  // to zero so back-to-back traffic is seen too.
  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      in_kelvin  <= 16'd0;
      gap_left   <= 0;
      words_sent <= 0;
    end else begin
      if (start && !busy) begin
        rgb_expected.push_back(kelvin_to_rgb(in_kelvin));
        words_sent <= words_sent + 1;
      end
      if (start && busy) begin
        // hold the current word until it is taken
      end else if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (kelvin_queue.size() > 0) begin
        start     <= 1'b1;
        in_kelvin <= kelvin_queue.pop_front();
        // long stretches of no idling, otherwise random gaps
        gap_left  <= (($urandom_range(0, 3) == 0) ? 0 :
                      ((words_sent / 200) % 2 == 1) ? 0 : $urandom_range(0, 14));
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_valid) begin
      if (rgb_expected.size() == 0) begin
        $error("unexpected word: red %0d green %0d blue %0d", out_red, out_green, out_blue);
        errors = errors + 1;
      end else begin
        want = rgb_expected.pop_front();
        if (out_red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, out_red);
          errors = errors + 1;
        end
        if (out_green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, out_green);
          errors = errors + 1;
        end
        if (out_blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, out_blue);
          errors = errors + 1;
        end
        words_checked = words_checked + 1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin
    logic [15:0] directed[$];
    int          sel;
    directed = '{16'd0, 16'd1, 16'd99, 16'd100, 16'd101, 16'd1899, 16'd1900,
                 16'd1901, 16'd1000, 16'd3500, 16'd6599, 16'd6600, 16'd6601,
                 16'd6500, 16'd10000, 16'd40000, 16'd65535, 16'hAAAA, 16'h5555,
                 16'd2700, 16'd5000};
    rst_n         = 1'b0;
    foreach (directed[i]) kelvin_queue.push_back(directed[i]);
    // random part: mostly the useful 1000..40000 K span, with knees and the whole range
    for (int i = 0; i < 1830; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5)      kelvin_queue.push_back(16'($urandom_range(1000, 40000)));
      else if (sel < 7) kelvin_queue.push_back(16'($urandom_range(0, 65535)));
      else if (sel < 8) kelvin_queue.push_back(16'($urandom_range(6580, 6620)));
      else if (sel < 9) kelvin_queue.push_back(16'($urandom_range(1880, 1920)));
      else              kelvin_queue.push_back(16'($urandom_range(0, 200)));
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (kelvin_queue.size() == 0 && !start);
    wait (rgb_expected.size() == 0);
    repeat (LAT + 10) @(posedge clk);
    $display("Checked %0d conversions across 0..65535 K, including both curve knees.",
             words_checked);
    if (errors == 0 && rgb_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: ends the run with an error if ~1850 words and the pipeline fill have not finished by then
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: color_temperature_to_rgb_top.f
sv/ctrgb_pkg.sv
sv/color_temperature_to_rgb_top.sv
bench/color_temperature_to_rgb_top_test.sv
